// File: rtl/core/lsra_pkg.sv
// Shared types and codes for the linear scan register allocator
`timescale 1ns / 1ps
package lsra_pkg;

  localparam logic [1:0] ACT_BEGIN    = 2'd0;
  localparam logic [1:0] ACT_INTERVAL = 2'd1;
  localparam logic [1:0] ACT_FINISH   = 2'd2;

  localparam logic [1:0] KIND_ASSIGN = 2'd0;
  localparam logic [1:0] KIND_EVICT  = 2'd1;
  localparam logic [1:0] KIND_TOTAL  = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam int unsigned POS_W  = 16;
  localparam int unsigned VREG_W = 16;
  localparam int unsigned PREG_W = 5;
  localparam int unsigned CNT_W  = 6;

  typedef struct packed {
    logic load;
    logic clear;
    logic scan_init;
    logic scan_step;
    logic emit_total;
    logic emit_error;
    logic take_free;
    logic evict;
    logic assign_evict;
    logic self_spill;
  } lsra_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       range_bad;
    logic       scan_done;
    logic       free_found;
    logic       evict_ok;
  } lsra_stat_t;

endpackage

// File: rtl/core/linear_scan_register_allocator.sv
// Top level of the linear scan register allocator
//
//  channel   handshake              payload
//  config    cfg_write              cfg_data (physical register count)
//  input     start && !busy         action, virtual_register, start_position, end_position
//  result    strobe (one cycle)     kind, result_register, physical_register, spilled,
//                                   spill_slot, spill_slot_total, last
//
// An interval transaction steps through dispatch, scan, drain, decide (and assign on
// eviction) states; the register table RAM is read one entry a cycle for expiry, free and
// eviction search. Begin, finish and range errors end after dispatch. busy falls in the
// cycle that shows the last result. rst clears the busy table and spill counter and sets
// the count to 32. The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
module linear_scan_register_allocator #(
  parameter int unsigned MAX_PHYS_REGS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [lsra_pkg::CNT_W-1:0]  cfg_data,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  action,
  input  logic [lsra_pkg::VREG_W-1:0] virtual_register,
  input  logic [lsra_pkg::POS_W-1:0]  start_position,
  input  logic [lsra_pkg::POS_W-1:0]  end_position,
  output logic                        strobe,
  output logic [1:0]                  kind,
  output logic [lsra_pkg::VREG_W-1:0] result_register,
  output logic [lsra_pkg::PREG_W-1:0] physical_register,
  output logic                        spilled,
  output logic [lsra_pkg::POS_W-1:0]  spill_slot,
  output logic [lsra_pkg::POS_W-1:0]  spill_slot_total,
  output logic                        last
);

  lsra_pkg::lsra_cmd_t  cmd;
  lsra_pkg::lsra_stat_t stat;

  lsra_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  lsra_datapath #(
    .MAX_PHYS_REGS (MAX_PHYS_REGS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_write         (cfg_write),
    .cfg_data          (cfg_data),
    .action            (action),
    .virtual_register  (virtual_register),
    .start_position    (start_position),
    .end_position      (end_position),
    .strobe            (strobe),
    .kind              (kind),
    .result_register   (result_register),
    .physical_register (physical_register),
    .spilled           (spilled),
    .spill_slot        (spill_slot),
    .spill_slot_total  (spill_slot_total),
    .last              (last)
  );

`ifndef NO_ASSERTIONS
  a_evict_then_assign: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind == lsra_pkg::KIND_EVICT) |=>
      strobe && (kind == lsra_pkg::KIND_ASSIGN) && last &&
      (physical_register == $past(physical_register)))
    else $error("eviction not followed by assignment of the same register");

  a_evict_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind == lsra_pkg::KIND_EVICT) |-> !last && spilled && busy)
    else $error("eviction result malformed");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("block busy while last result issued");

  a_self_spill_reg: assert property (@(posedge clk) disable iff (rst)
    strobe && spilled && (kind == lsra_pkg::KIND_ASSIGN) |-> (physical_register == '0))
    else $error("self spill carries a physical register");
`endif

endmodule

// File: rtl/core/lsra_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module lsra_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/lsra_ctrl.sv
// Controller state machine for the linear scan register allocator
`timescale 1ns / 1ps
module lsra_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  lsra_pkg::lsra_stat_t stat,
  output lsra_pkg::lsra_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_ASSIGN
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_IDLE;
        unique case (stat.action)
          lsra_pkg::ACT_BEGIN: cmd.clear = 1'b1;
          lsra_pkg::ACT_FINISH: cmd.emit_total = 1'b1;
          lsra_pkg::ACT_INTERVAL: begin
            if (stat.range_bad) begin
              cmd.emit_error = 1'b1;
            end else begin
              cmd.scan_init = 1'b1;
              state_next    = S_SCAN;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_DECIDE;
      S_DECIDE: begin
        state_next = S_IDLE;
        if (stat.free_found) begin
          cmd.take_free = 1'b1;
        end else if (stat.evict_ok) begin
          cmd.evict  = 1'b1;
          state_next = S_ASSIGN;
        end else begin
          cmd.self_spill = 1'b1;
        end
      end
      S_ASSIGN: begin
        cmd.assign_evict = 1'b1;
        state_next       = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// File: rtl/core/lsra_datapath.sv
// Datapath: interval latch, register table scan, spill counter, result registers
`timescale 1ns / 1ps
module lsra_datapath #(
  parameter int unsigned MAX_PHYS_REGS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lsra_pkg::lsra_cmd_t           cmd,
  output lsra_pkg::lsra_stat_t          stat,
  input  logic                          cfg_write,
  input  logic [lsra_pkg::CNT_W-1:0]    cfg_data,
  input  logic [1:0]                    action,
  input  logic [lsra_pkg::VREG_W-1:0]   virtual_register,
  input  logic [lsra_pkg::POS_W-1:0]    start_position,
  input  logic [lsra_pkg::POS_W-1:0]    end_position,
  output logic                          strobe,
  output logic [1:0]                    kind,
  output logic [lsra_pkg::VREG_W-1:0]   result_register,
  output logic [lsra_pkg::PREG_W-1:0]   physical_register,
  output logic                          spilled,
  output logic [lsra_pkg::POS_W-1:0]    spill_slot,
  output logic [lsra_pkg::POS_W-1:0]    spill_slot_total,
  output logic                          last
);

  localparam int unsigned IDX_W  = (MAX_PHYS_REGS > 1) ? $clog2(MAX_PHYS_REGS) : 1;
  localparam int unsigned CMP_W  = lsra_pkg::CNT_W + 1;
  localparam int unsigned WORD_W = lsra_pkg::POS_W + lsra_pkg::VREG_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PHYS_REGS - 1);

  logic [1:0]                  act;
  logic [lsra_pkg::VREG_W-1:0] vreg;
  logic [lsra_pkg::POS_W-1:0]  start_pos;
  logic [lsra_pkg::POS_W-1:0]  end_pos;
  logic [lsra_pkg::CNT_W-1:0]  reg_count;
  logic [MAX_PHYS_REGS-1:0]    busy_vec;
  logic [lsra_pkg::POS_W-1:0]  spill_cnt;

  logic [IDX_W-1:0]            idx;
  logic                        rd_valid;
  logic [IDX_W-1:0]            rd_idx;
  logic [WORD_W-1:0]           rd_data;

  logic                        free_found;
  logic [IDX_W-1:0]            free_idx;
  logic                        cand_valid;
  logic [IDX_W-1:0]            cand_idx;
  logic [lsra_pkg::POS_W-1:0]  cand_end;
  logic [lsra_pkg::VREG_W-1:0] cand_owner;

  logic [lsra_pkg::POS_W-1:0]  e_end;
  logic [lsra_pkg::VREG_W-1:0] e_owner;
  logic                        e_busy;
  logic                        e_expire;
  logic                        e_live;
  logic                        e_free;
  logic                        e_better;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;

  assign e_end    = rd_data[WORD_W-1 -: lsra_pkg::POS_W];
  assign e_owner  = rd_data[lsra_pkg::VREG_W-1:0];
  assign e_busy   = busy_vec[rd_idx];
  assign e_expire = e_busy && (e_end < start_pos);
  assign e_live   = e_busy && !e_expire;
  assign e_free   = !e_live && (CMP_W'(rd_idx) < CMP_W'(reg_count));
  assign e_better = !cand_valid || (e_end > cand_end) ||
                    ((e_end == cand_end) && (e_owner >= cand_owner));

  assign stat.action     = act;
  assign stat.range_bad  = end_pos < start_pos;
  assign stat.scan_done  = (idx == LAST_IDX);
  assign stat.free_found = free_found;
  assign stat.evict_ok   = cand_valid && ((cand_end > end_pos) ||
                           ((cand_end == end_pos) && (cand_owner > vreg)));

  assign wr_en   = cmd.take_free || cmd.evict;
  assign wr_addr = cmd.take_free ? free_idx : cand_idx;

  lsra_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_PHYS_REGS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({end_pos, vreg}),
    .rd_en   (cmd.scan_step),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act       <= action;
      vreg      <= virtual_register;
      start_pos <= start_position;
      end_pos   <= end_position;
    end
    if (cmd.scan_init) begin
      idx <= '0;
    end else if (cmd.scan_step) begin
      idx <= idx + 1'b1;
    end
    rd_idx <= idx;
    if (cmd.scan_init) begin
      free_found <= 1'b0;
      cand_valid <= 1'b0;
    end else if (rd_valid) begin
      if (e_free && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
      if (e_live && e_better) begin
        cand_valid <= 1'b1;
        cand_idx   <= rd_idx;
        cand_end   <= e_end;
        cand_owner <= e_owner;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_count <= lsra_pkg::CNT_W'(32);
      busy_vec  <= '0;
      spill_cnt <= '0;
      rd_valid  <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_step;
      if (cfg_write) begin
        reg_count <= cfg_data;
      end
      if (cmd.clear) begin
        busy_vec  <= '0;
        spill_cnt <= '0;
      end else begin
        if (rd_valid && e_expire) begin
          busy_vec[rd_idx] <= 1'b0;
        end
        if (cmd.take_free) begin
          busy_vec[free_idx] <= 1'b1;
        end
        if (cmd.evict || cmd.self_spill) begin
          spill_cnt <= spill_cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_total || cmd.emit_error || cmd.take_free ||
                cmd.evict || cmd.assign_evict || cmd.self_spill;
    end
  end

  always_ff @(posedge clk) begin
    kind              <= lsra_pkg::KIND_ASSIGN;
    result_register   <= '0;
    physical_register <= '0;
    spilled           <= 1'b0;
    spill_slot        <= '0;
    spill_slot_total  <= '0;
    last              <= 1'b1;
    if (cmd.emit_total) begin
      kind             <= lsra_pkg::KIND_TOTAL;
      spill_slot_total <= spill_cnt;
    end else if (cmd.emit_error) begin
      kind            <= lsra_pkg::KIND_ERROR;
      result_register <= vreg;
    end else if (cmd.take_free) begin
      result_register   <= vreg;
      physical_register <= lsra_pkg::PREG_W'(free_idx);
    end else if (cmd.evict) begin
      kind              <= lsra_pkg::KIND_EVICT;
      result_register   <= cand_owner;
      physical_register <= lsra_pkg::PREG_W'(cand_idx);
      spilled           <= 1'b1;
      spill_slot        <= spill_cnt;
      last              <= 1'b0;
    end else if (cmd.assign_evict) begin
      result_register   <= vreg;
      physical_register <= lsra_pkg::PREG_W'(cand_idx);
    end else if (cmd.self_spill) begin
      result_register <= vreg;
      spilled         <= 1'b1;
      spill_slot      <= spill_cnt;
    end
  end

endmodule
